### src/teletext_x26_triplet_decoder_assert.svh
// Assertion macros for the teletext X/26 triplet decoder.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef TELETEXT_X26_TRIPLET_DECODER_ASSERT_SVH
`define TELETEXT_X26_TRIPLET_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TTX_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("teletext x26 decoder: check failed");

// Next-cycle implication, checked outside reset.
`define TTX_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("teletext x26 decoder: check failed");

`endif

### src/ttx26_pkg.sv
// Shared types and constants for the teletext X/26 triplet decoder.
// No dependencies; used by ttx26_decode, the top level and the testbench.
package ttx26_pkg;

    localparam int TripletW = 18;
    localparam int RowW     = 5;
    localparam int ColW     = 6;
    localparam int G2W      = 4;
    localparam int IdxW     = 7;
    localparam int DiacW    = 4;
    localparam int TselW    = 2;

    localparam logic [4:0] MODE_G3      = 5'h02;
    localparam logic [4:0] MODE_SET_POS = 5'h04;
    localparam logic [4:0] MODE_ROW0    = 5'h07;
    localparam logic [4:0] MODE_G2      = 5'h0F;
    localparam logic [4:0] MODE_DIAC_LO = 5'h10;
    localparam logic [4:0] MODE_DIAC_HI = 5'h1F;

    localparam logic [10:0] TERM_MARK     = 11'h7FF;
    localparam logic [5:0]  HOME_ADDR     = 6'h1F;
    localparam logic [5:0]  ROW24_ADDR    = 6'd40;
    localparam logic [5:0]  COLUMN_LIMIT  = 6'd40;
    localparam logic [6:0]  AT_SIGN_DATA  = 7'h2A;
    localparam logic [6:0]  AT_SIGN_INDEX = 7'h40;
    localparam logic [6:0]  PRINT_BASE    = 7'h20;
    localparam logic [4:0]  LAST_ROW      = 5'd24;

    localparam logic [TselW-1:0] TSEL_G0 = 2'd0;
    localparam logic [TselW-1:0] TSEL_G2 = 2'd1;
    localparam logic [TselW-1:0] TSEL_G3 = 2'd2;

    localparam logic [G2W-1:0] G2_RESET = 4'd0;

    // position state carried between triplets
    typedef struct packed {
        logic [RowW-1:0] row;
        logic [ColW-1:0] column;
        logic            ended;
    } t_pos_state;

    // per-triplet character write info
    typedef struct packed {
        logic             write_valid;
        logic [TselW-1:0] table_select;
        logic [IdxW-1:0]  char_index;
        logic [DiacW-1:0] diacritic;
    } t_char_write;

endpackage

### src/ttx26_decode.sv
// Combinational triplet decode: next position state and character write.
// Depends on ttx26_pkg.
module ttx26_decode (
    input  logic [ttx26_pkg::TripletW-1:0] i_triplet,
    input  logic                           i_page_start,
    input  ttx26_pkg::t_pos_state          i_state,
    output ttx26_pkg::t_pos_state          o_state,
    output ttx26_pkg::t_char_write         o_write
);

    logic [5:0] w_addr;
    logic [4:0] w_mode;
    logic [6:0] w_data;
    ttx26_pkg::t_pos_state w_base;

    assign w_addr = i_triplet[5:0];
    assign w_mode = i_triplet[10:6];
    assign w_data = i_triplet[17:11];

    always_comb begin
        w_base = i_state;
        if (i_page_start) begin
            w_base = '0;
        end
    end

    always_comb begin
        o_state = w_base;
        o_write = '0;
        if (!w_base.ended) begin
            if (i_triplet[10:0] == ttx26_pkg::TERM_MARK) begin
                o_state.ended = 1'b1;
            end else begin
                unique case (w_mode) inside
                    ttx26_pkg::MODE_SET_POS: begin
                        if (w_addr < ttx26_pkg::ROW24_ADDR) begin
                            o_state.row = '0;
                        end else if (w_addr == ttx26_pkg::ROW24_ADDR) begin
                            o_state.row = ttx26_pkg::LAST_ROW;
                        end else begin
                            o_state.row = 5'(w_addr - ttx26_pkg::ROW24_ADDR);
                        end
                        o_state.column = (w_data < 7'(ttx26_pkg::COLUMN_LIMIT))
                                         ? w_data[5:0] : '0;
                    end
                    ttx26_pkg::MODE_ROW0: begin
                        if (w_addr == ttx26_pkg::HOME_ADDR) begin
                            o_state.row    = '0;
                            o_state.column = '0;
                        end
                    end
                    ttx26_pkg::MODE_G3, ttx26_pkg::MODE_G2,
                    [ttx26_pkg::MODE_DIAC_LO:ttx26_pkg::MODE_DIAC_HI]: begin
                        o_state.column = (w_addr < ttx26_pkg::COLUMN_LIMIT) ? w_addr : '0;
                        if (w_data >= ttx26_pkg::PRINT_BASE) begin
                            o_write.write_valid = 1'b1;
                            o_write.char_index  = w_data - ttx26_pkg::PRINT_BASE;
                            if (w_mode == ttx26_pkg::MODE_G3) begin
                                o_write.table_select = ttx26_pkg::TSEL_G3;
                            end else if (w_mode == ttx26_pkg::MODE_G2) begin
                                o_write.table_select = ttx26_pkg::TSEL_G2;
                            end else begin
                                o_write.table_select = ttx26_pkg::TSEL_G0;
                                o_write.diacritic    = w_mode[3:0];
                                if (w_mode == ttx26_pkg::MODE_DIAC_LO &&
                                    w_data == ttx26_pkg::AT_SIGN_DATA) begin
                                    o_write.char_index = ttx26_pkg::AT_SIGN_INDEX;
                                end
                            end
                        end
                    end
                    default: begin
                        // other modes leave the position alone
                    end
                endcase
            end
        end
    end

endmodule

### src/teletext_x26_triplet_decoder.sv
// Teletext X/26 enhancement triplet decoder, top level.
// A triplet is held in the input register, decoded, then held in the result register.
// Throughput: one triplet per cycle unless m_axis_tready stalls; r_state loops through decode.
// While a result waits, the input register takes one more triplet, then s_axis_tready drops.
// Reset (i_rst_n low, synchronous): position, end flag, G2 select and both valids clear.
// Depends on ttx26_pkg, ttx26_decode and the assertion macro header.
`include "teletext_x26_triplet_decoder_assert.svh"

module teletext_x26_triplet_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // G2 charset select
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    // triplet stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [17:0] triplet, [23:18] zero
    input  logic [0:0]  s_axis_tuser,   // [0] page_start
    // decoded stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [4:0] row, [10:5] column, [14:11] g2_set,
                                        // [21:15] char_index, [25:22] diacritic, [31:26] zero
    output logic [3:0]  m_axis_tuser    // [0] write_valid, [2:1] table_select, [3] terminated
);

    // input register
    logic                            r_in_valid, n_in_valid;
    logic [ttx26_pkg::TripletW-1:0]  r_triplet;
    logic                            r_page_start;

    // position state and config
    ttx26_pkg::t_pos_state           r_state;
    logic [ttx26_pkg::G2W-1:0]       r_g2;

    // result register
    logic                            r_out_valid, n_out_valid;
    ttx26_pkg::t_pos_state           r_out_state;
    ttx26_pkg::t_char_write          r_out_write;
    logic [ttx26_pkg::G2W-1:0]       r_out_g2;

    ttx26_pkg::t_pos_state           w_next_state;
    ttx26_pkg::t_char_write          w_write;
    logic                            w_advance;   // result register can take a new value
    logic                            w_fire;      // decode stage moves this cycle
    logic                            w_in_xact;
    logic                            w_pos_ok;    // result position on the page grid

    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;
    assign w_in_xact     = s_axis_tvalid && s_axis_tready;

    ttx26_decode u_decode (
        .i_triplet    (r_triplet),
        .i_page_start (r_page_start),
        .i_state      (r_state),
        .o_state      (w_next_state),
        .o_write      (w_write)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_xact) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
            r_g2        <= ttx26_pkg::G2_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            if (w_fire) begin
                r_state <= w_next_state;
            end
            if (i_cfg_wr_en) begin
                r_g2 <= i_cfg_wr_data;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_in_xact) begin
            r_triplet    <= s_axis_tdata[ttx26_pkg::TripletW-1:0];
            r_page_start <= s_axis_tuser[0];
        end
        if (w_fire) begin
            r_out_state <= w_next_state;
            r_out_write <= w_write;
            r_out_g2    <= r_g2;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0,
                            r_out_write.diacritic,
                            r_out_write.char_index,
                            r_out_g2,
                            r_out_state.column,
                            r_out_state.row};
    assign m_axis_tuser  = {r_out_state.ended,
                            r_out_write.table_select,
                            r_out_write.write_valid};

    assign w_pos_ok = (r_out_state.row <= ttx26_pkg::LAST_ROW) &&
                      (r_out_state.column < ttx26_pkg::COLUMN_LIMIT);

    // a terminated page never carries a character write
    `TTX_ASSERT_NOW(a_no_write_after_end, r_out_valid && r_out_state.ended, !r_out_write.write_valid)
    // only G0, G2 and G3 tables are ever selected
    `TTX_ASSERT_NOW(a_tsel_legal, r_out_valid, r_out_write.table_select <= ttx26_pkg::TSEL_G3)
    // the active position stays on the page grid
    `TTX_ASSERT_NOW(a_pos_range, r_out_valid, w_pos_ok)
    // outside reset, the end flag only clears through a page start
    `TTX_ASSERT_NEXT(a_end_sticky, r_state.ended && !(w_fire && r_page_start), r_state.ended)

endmodule

### tb/sv/teletext_x26_triplet_decoder_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for teletext_x26_triplet_decoder: stream traffic, G2 select writes.
// Depends on ttx26_pkg and the decoder RTL; a scoreboard class predicts every result.
module teletext_x26_triplet_decoder_tb;

    // X/26 modes the decoder ignores, used by name in the directed part
    localparam logic [4:0] MODE_SCREEN_COLOR = 5'h00;
    localparam logic [4:0] MODE_ROW_COLOR    = 5'h01;
    localparam logic [4:0] MODE_PDC          = 5'h08;

    localparam int unsigned HOLD_OFF_CYCLES = 200;   // long receiver stall
    localparam int unsigned QUIET_LIMIT     = 2000;  // watchdog: cycles with no transaction
    localparam int unsigned TAIL_CYCLES     = 8;     // extra wait after the last drain

    typedef enum {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_PATTERN} t_rx_style;

    // one decoded result, split into its fields
    typedef struct packed {
        logic                        write_valid;
        logic [ttx26_pkg::RowW-1:0]  row;
        logic [ttx26_pkg::ColW-1:0]  column;
        logic [ttx26_pkg::TselW-1:0] table_select;
        logic [ttx26_pkg::G2W-1:0]   g2_set;
        logic [ttx26_pkg::IdxW-1:0]  char_index;
        logic [ttx26_pkg::DiacW-1:0] diacritic;
        logic                        terminated;
    } t_x26_result;

    // ------------------------------------------------------------------
    // Scoreboard: own copy of the position state and the G2 select,
    // a queue of expected results, and the mismatch count.
    // ------------------------------------------------------------------
    class t_x26_scoreboard;
        logic [ttx26_pkg::RowW-1:0] cur_row;
        logic [ttx26_pkg::ColW-1:0] cur_col;
        logic                       page_done;
        logic [ttx26_pkg::G2W-1:0]  g2_sel;
        t_x26_result                expected_writes[$];
        int unsigned                mismatches;

        function void clear_state();
            cur_row   = '0;
            cur_col   = '0;
            page_done = 1'b0;
            g2_sel    = ttx26_pkg::G2_RESET;
            expected_writes.delete();
            mismatches = 0;
        endfunction

        function int pending();
            return expected_writes.size();
        endfunction

        task report_mismatch(string what, int unsigned got, int unsigned want);
            mismatches++;
            $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        endtask

        // Decode one triplet against the tracked position; returns the expected result.
        function t_x26_result decode_triplet(logic [ttx26_pkg::TripletW-1:0] t, logic ps);
            t_x26_result r;
            logic [5:0]  addr;
            logic [4:0]  mode;
            logic [6:0]  data;
            logic [5:0]  row_off;
            addr = t[5:0];
            mode = t[10:6];
            data = t[17:11];
            r    = '0;
            if (ps) begin
                cur_row   = '0;
                cur_col   = '0;
                page_done = 1'b0;
            end
            if (!page_done) begin
                if (t[10:0] == ttx26_pkg::TERM_MARK) begin
                    page_done = 1'b1;
                end else if (mode == ttx26_pkg::MODE_SET_POS) begin
                    // address 40 is row 24, 41..63 are rows 1..23, below 40 gives row 0
                    row_off = addr - ttx26_pkg::ROW24_ADDR;
                    if (addr < ttx26_pkg::ROW24_ADDR)
                        cur_row = '0;
                    else if (addr == ttx26_pkg::ROW24_ADDR)
                        cur_row = ttx26_pkg::LAST_ROW;
                    else
                        cur_row = row_off[4:0];
                    cur_col = (data < 7'(ttx26_pkg::COLUMN_LIMIT)) ? data[5:0] : '0;
                end else if (mode == ttx26_pkg::MODE_ROW0) begin
                    if (addr == ttx26_pkg::HOME_ADDR) begin
                        cur_row = '0;
                        cur_col = '0;
                    end
                end else if (mode == ttx26_pkg::MODE_G3 || mode == ttx26_pkg::MODE_G2 ||
                             mode >= ttx26_pkg::MODE_DIAC_LO) begin
                    cur_col = (addr < ttx26_pkg::COLUMN_LIMIT) ? addr : '0;
                    if (data >= ttx26_pkg::PRINT_BASE) begin
                        r.write_valid = 1'b1;
                        r.char_index  = data - ttx26_pkg::PRINT_BASE;
                        if (mode == ttx26_pkg::MODE_G3) begin
                            r.table_select = ttx26_pkg::TSEL_G3;
                        end else if (mode == ttx26_pkg::MODE_G2) begin
                            r.table_select = ttx26_pkg::TSEL_G2;
                        end else begin
                            r.table_select = ttx26_pkg::TSEL_G0;
                            r.diacritic    = mode[3:0];
                            // at-sign special case in the G0 set without diacritic
                            if (mode == ttx26_pkg::MODE_DIAC_LO &&
                                data == ttx26_pkg::AT_SIGN_DATA)
                                r.char_index = ttx26_pkg::AT_SIGN_INDEX;
                        end
                    end
                end
            end
            r.row        = cur_row;
            r.column     = cur_col;
            r.g2_set     = g2_sel;
            r.terminated = page_done;
            return r;
        endfunction

        function void note_triplet(logic [ttx26_pkg::TripletW-1:0] t, logic ps);
            expected_writes.push_back(decode_triplet(t, ps));
        endfunction

        task cmp_field(string field, int unsigned got, int unsigned want);
            if (got != want)
                report_mismatch(field, got, want);
        endtask

        task check_result(logic [31:0] d, logic [3:0] u);
            t_x26_result want;
            if (expected_writes.size() == 0) begin
                report_mismatch("result with no triplet outstanding", 32'(d), 0);
                return;
            end
            want = expected_writes.pop_front();
            cmp_field("write_valid",  32'(u[0]),     32'(want.write_valid));
            cmp_field("table_select", 32'(u[2:1]),   32'(want.table_select));
            cmp_field("terminated",   32'(u[3]),     32'(want.terminated));
            cmp_field("row",          32'(d[4:0]),   32'(want.row));
            cmp_field("column",       32'(d[10:5]),  32'(want.column));
            cmp_field("g2_set",       32'(d[14:11]), 32'(want.g2_set));
            cmp_field("char_index",   32'(d[21:15]), 32'(want.char_index));
            cmp_field("diacritic",    32'(d[25:22]), 32'(want.diacritic));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT signals; the inputs are known from time 0
    // ------------------------------------------------------------------
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [3:0]  i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // [17:0] triplet, [23:18] zero
    logic [0:0]  s_axis_tuser  = '0;   // [0] page_start
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // [4:0] row, [10:5] column, [14:11] g2_set,
                                       // [21:15] char_index, [25:22] diacritic
    logic [3:0]  m_axis_tuser;         // [0] write_valid, [2:1] table_select, [3] terminated

    t_x26_scoreboard sb;
    t_rx_style       rx_style     = RX_ALWAYS;
    logic            hold_off_req = 1'b0;    // main asks the receiver for one long stall
    int unsigned     quiet_cycles = 0;

    teletext_x26_triplet_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: both transactions are sampled at the edge that accepts them.
    // Values read here are the ones settled before the edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_triplet(s_axis_tdata[ttx26_pkg::TripletW-1:0], s_axis_tuser[0]);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog: a long run of cycles with no transaction on either side ends the run.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] watchdog: no transaction for %0d cycles", $realtime, quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: ready follows the current style; a hold-off request drops
    // ready for a long stretch so the result register and input both stall.
    // ------------------------------------------------------------------
    initial begin : rx_side
        int unsigned tick;
        tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                case (rx_style)
                    RX_ALWAYS:  m_axis_tready <= 1'b1;
                    RX_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) == 0);
                    RX_PATTERN: m_axis_tready <= ((tick % 5) >= 2);
                    default:    m_axis_tready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------
    function automatic logic [ttx26_pkg::TripletW-1:0] triplet_of(logic [6:0] data,
                                                                  logic [4:0] mode,
                                                                  logic [5:0] addr);
        return {data, mode, addr};
    endfunction

    // Offer one triplet and wait for the edge that takes it. Valid stays high
    // afterwards; the caller lowers it only when a gap follows.
    task automatic send_triplet(input logic [ttx26_pkg::TripletW-1:0] t, input logic ps);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, t};
        s_axis_tuser  <= ps;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic pause_sender(input int unsigned n);
        if (n != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Stop offering and wait until every expected result has come back.
    // An edge is awaited first so the monitor has logged the last accepted triplet.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    // G2 select write; only called with nothing in flight
    task automatic write_g2(input logic [3:0] v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.g2_sel = v;
    endtask

    // Random triplet, biased toward well-formed character and position triplets
    // so the position state and the write path get most of the traffic.
    function automatic void roll_triplet(output logic [ttx26_pkg::TripletW-1:0] t,
                                         output logic ps);
        int unsigned pick;
        int unsigned sel;
        logic [5:0]  addr;
        logic [4:0]  mode;
        logic [6:0]  data;
        logic [31:0] rnd;
        pick = $urandom_range(0, 99);
        ps   = ($urandom_range(0, 99) < 6);
        addr = 6'($urandom_range(0, 63));
        mode = 5'($urandom_range(0, 31));
        data = 7'($urandom_range(0, 127));
        rnd  = $urandom;
        if (pick < 40) begin
            // character write: G3, G2 or G0 with any diacritic
            sel = $urandom_range(0, 17);
            if (sel == 0)
                mode = ttx26_pkg::MODE_G3;
            else if (sel == 1)
                mode = ttx26_pkg::MODE_G2;
            else
                mode = ttx26_pkg::MODE_DIAC_LO + 5'(sel - 2);
            if ($urandom_range(0, 3) != 0)
                addr = 6'($urandom_range(0, int'(ttx26_pkg::COLUMN_LIMIT) - 1));
            if ($urandom_range(0, 9) == 0)
                data = ttx26_pkg::AT_SIGN_DATA;
            else if ($urandom_range(0, 5) != 0)
                data = 7'($urandom_range(int'(ttx26_pkg::PRINT_BASE), 127));
        end else if (pick < 60) begin
            mode = ttx26_pkg::MODE_SET_POS;
            if ($urandom_range(0, 4) != 0)
                addr = 6'($urandom_range(int'(ttx26_pkg::ROW24_ADDR), 63));
            if ($urandom_range(0, 3) != 0)
                data = 7'($urandom_range(0, int'(ttx26_pkg::COLUMN_LIMIT) - 1));
        end else if (pick < 66) begin
            mode = ttx26_pkg::MODE_ROW0;
            if ($urandom_range(0, 4) != 0)
                addr = ttx26_pkg::HOME_ADDR;
        end
        t = {data, mode, addr};
        if (pick >= 66 && pick < 69)
            t = {data, ttx26_pkg::TERM_MARK};            // end of page
        else if (pick >= 69)
            t = rnd[ttx26_pkg::TripletW-1:0];            // anything at all
    endfunction

    // Bursts of random length, random gaps up to max_gap between them
    task automatic send_random(input int count, input int unsigned max_gap);
        logic [ttx26_pkg::TripletW-1:0] t;
        logic                           ps;
        int                             left;
        left = 0;
        for (int i = 0; i < count; i++) begin
            if (left == 0) begin
                left = $urandom_range(1, 24);
                if (max_gap > 0)
                    pause_sender($urandom_range(0, max_gap));
            end
            roll_triplet(t, ps);
            send_triplet(t, ps);
            left--;
        end
    endtask

    // Field extremes, every mode class, the at-sign case, home, termination
    // and the page start that clears it.
    task automatic send_directed();
        send_triplet(triplet_of(7'd0,  ttx26_pkg::MODE_SET_POS, ttx26_pkg::ROW24_ADDR), 1'b1);
        send_triplet(triplet_of(7'd39, ttx26_pkg::MODE_SET_POS, 6'd63), 1'b0);  // row 23
        send_triplet(triplet_of(7'h7F, ttx26_pkg::MODE_SET_POS, 6'd39), 1'b0);  // row 0
        send_triplet(triplet_of(7'd40, ttx26_pkg::MODE_SET_POS, 6'd41), 1'b0);  // row 1
        send_triplet(triplet_of(7'h7F, ttx26_pkg::MODE_G3, 6'd0), 1'b0);        // last G3
        send_triplet(triplet_of(ttx26_pkg::PRINT_BASE, ttx26_pkg::MODE_G2, 6'd39), 1'b0);
        send_triplet(triplet_of(7'h1F, ttx26_pkg::MODE_G2, 6'd40), 1'b0);       // unprintable
        send_triplet(triplet_of(ttx26_pkg::AT_SIGN_DATA, ttx26_pkg::MODE_DIAC_LO, 6'd5),
                     1'b0);                                                      // at-sign
        send_triplet(triplet_of(7'h2B, ttx26_pkg::MODE_DIAC_LO, 6'd6), 1'b0);
        send_triplet(triplet_of(ttx26_pkg::AT_SIGN_DATA, ttx26_pkg::MODE_DIAC_LO + 5'd1,
                                6'd7), 1'b0);
        send_triplet(triplet_of(7'h7F, ttx26_pkg::MODE_DIAC_HI, 6'd62), 1'b0);  // diacritic 15
        send_triplet(triplet_of(7'd0,  ttx26_pkg::MODE_DIAC_LO + 5'd4, 6'd10), 1'b0);
        send_triplet(triplet_of(7'd0,  ttx26_pkg::MODE_ROW0, ttx26_pkg::HOME_ADDR - 6'd1),
                     1'b0);                                                      // not home
        send_triplet(triplet_of(7'h55, ttx26_pkg::MODE_ROW0, ttx26_pkg::HOME_ADDR), 1'b0);
        send_triplet(triplet_of(7'd20, ttx26_pkg::MODE_SET_POS, 6'd50), 1'b0);
        send_triplet(triplet_of(7'h7F, MODE_SCREEN_COLOR, 6'd3), 1'b0);         // ignored modes
        send_triplet(triplet_of(7'h41, MODE_ROW_COLOR, 6'd33), 1'b0);
        send_triplet(triplet_of(7'h33, MODE_PDC, 6'd12), 1'b0);
        send_triplet({7'd0, ttx26_pkg::TERM_MARK}, 1'b0);                       // page ends
        send_triplet(triplet_of(7'h50, ttx26_pkg::MODE_DIAC_LO + 5'd2, 6'd8), 1'b0);
        send_triplet(triplet_of(7'd5,  ttx26_pkg::MODE_SET_POS, 6'd45), 1'b0);
        send_triplet({7'h7F, ttx26_pkg::TERM_MARK}, 1'b1);                      // start, end
        send_triplet(triplet_of(7'h55, ttx26_pkg::MODE_G3, 6'd63), 1'b1);       // fresh page
        send_triplet('0, 1'b0);
        send_triplet({ttx26_pkg::TripletW{1'b1}}, 1'b0);                        // all ones
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, then phases with different G2 selects and
    // receiver styles; each phase drains before the next register write.
    // ------------------------------------------------------------------
    initial begin : main_seq
        sb = new;
        sb.clear_state();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, receiver always ready, top G2 select
        write_g2(4'hF);
        rx_style = RX_ALWAYS;
        send_directed();
        drain();

        write_g2(4'h0);
        rx_style = RX_RANDOM;
        send_random(250, 6);
        drain();

        // long receiver stall while the sender keeps offering back to back
        write_g2(4'h5);
        rx_style = RX_SPARSE;
        hold_off_req = 1'b1;
        send_random(80, 0);
        drain();
        send_random(170, 4);
        drain();

        write_g2(4'hA);
        rx_style = RX_PATTERN;
        send_random(250, 10);
        drain();

        // no idling on either side
        write_g2(4'($urandom_range(0, 15)));
        rx_style = RX_ALWAYS;
        send_random(300, 0);
        drain();

        write_g2(4'hF);
        rx_style = RX_RANDOM;
        send_random(250, 3);
        drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch("expected results left over", sb.pending(), 0);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/ttx26_pkg.sv
src/ttx26_decode.sv
src/teletext_x26_triplet_decoder.sv
tb/sv/teletext_x26_triplet_decoder_tb.sv
